>>> rtl/iss_pkg.sv
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Shared constants, beat types and per-cell control for the sequence store.
// ----------------------------------------------------------------------------
package iss_pkg;

	localparam int CAPACITY  = 16;
	localparam int WORD_BITS = 32;
	localparam int EXT_BITS  = 64;

	localparam int POS_W = 8;
	localparam int LEN_W = 5;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [2:0] MODE_APPEND  = 3'd0;
	localparam logic [2:0] MODE_PREPEND = 3'd1;
	localparam logic [2:0] MODE_INSERT  = 3'd2;
	localparam logic [2:0] MODE_REMOVE  = 3'd3;
	localparam logic [2:0] MODE_READ    = 3'd4;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic [POS_W-1:0]  position;
		logic signed [31:0] data_word;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] result_word;
		logic [LEN_W-1:0]   list_length;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic from_left;
		logic from_right;
	} cell_ctrl_t;

	function automatic word_t store_word(input logic signed [31:0] raw);
		logic signed [EXT_BITS-1:0] ext;
		begin
			ext = EXT_BITS'(raw);
			return ext[WORD_BITS-1:0];
		end
	endfunction

	function automatic logic signed [31:0] load_word(input word_t w);
		logic signed [EXT_BITS-1:0] ext;
		begin
			ext = EXT_BITS'(signed'(w));
			return ext[31:0];
		end
	endfunction

endpackage

>>> rtl/iss_cell.sv
// ----------------------------------------------------------------------------
// Sequence store cell
// Holds one element and takes a new word, its left or its right neighbour.
// ----------------------------------------------------------------------------
module iss_cell
	import iss_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  word_t      new_word,
	input  word_t      left_word,
	input  word_t      right_word,
	output word_t      word
);

	word_t word_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			word_q <= new_word;
		end else if (ctrl.from_left) begin
			word_q <= left_word;
		end else if (ctrl.from_right) begin
			word_q <= right_word;
		end
	end

	assign word = word_q;

endmodule

>>> rtl/indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// Indexed sequence store
// Ordered list of signed words kept in a row of cells, head in cell zero.
//
//   channel  direction  payload  handshake
//   req      in         req_t    req_valid / req_stall
//   rsp      out        rsp_t    rsp_valid / rsp_stall
//
// Every request beat completes at the accepting edge: the row of cells shifts up or
// down at that edge, and the response is registered at that same
// edge and offered from the next cycle on.
// A new request is taken in every cycle unless a response is held stalled.
// Reset empties the list; cell contents are not cleared.
// The read or removed word is selected from the row by position.
// ----------------------------------------------------------------------------
module indexed_sequence_store
	import iss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_next;

	logic             accept;
	logic             is_full;
	logic             in_range;
	logic             do_ins;
	logic             do_rem;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] ins_pos;
	word_t            new_word;
	word_t            cells [CAPACITY];
	cell_ctrl_t       ctrl  [CAPACITY];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign pos_ext  = CMP_W'(req.position);
	assign cnt_ext  = CMP_W'(count_q);
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign in_range = (pos_ext < cnt_ext);
	assign new_word = store_word(req.data_word);

	always_comb begin
		do_ins   = 1'b0;
		do_rem   = 1'b0;
		ins_pos  = cnt_ext;
		rsp_next = '0;
		case (req.mode)
			MODE_APPEND, MODE_PREPEND, MODE_INSERT: begin
				if (is_full) begin
					rsp_next.status = STATUS_FULL;
				end else begin
					do_ins = 1'b1;
				end
				if (req.mode == MODE_PREPEND) begin
					ins_pos = '0;
				end else if (req.mode == MODE_INSERT && in_range) begin
					ins_pos = pos_ext;
				end
			end
			MODE_REMOVE, MODE_READ: begin
				if (in_range) begin
					rsp_next.result_word = load_word(cells[req.position[IDX_W-1:0]]);
					do_rem = (req.mode == MODE_REMOVE);
				end else begin
					rsp_next.status = STATUS_RANGE;
				end
			end
			default: begin
			end
		endcase
		if (do_ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_next = count_q - CNT_W'(1);
		end else begin
			count_next = count_q;
		end
		rsp_next.list_length = LEN_W'(count_next);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CMP_W-1:0] CELL_IDX = CMP_W'(i);
		word_t left_word;
		word_t right_word;

		if (i == 0) begin : g_head
			assign left_word = new_word;
		end else begin : g_body
			assign left_word = cells[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_word = cells[i];
		end else begin : g_mid
			assign right_word = cells[i+1];
		end

		always_comb begin
			ctrl[i].load       = accept && do_ins && (CELL_IDX == ins_pos);
			ctrl[i].from_left  = accept && do_ins && (CELL_IDX > ins_pos);
			ctrl[i].from_right = accept && do_rem && (CELL_IDX >= pos_ext);
		end

		iss_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[i]),
			.new_word   (new_word),
			.left_word  (left_word),
			.right_word (right_word),
			.word       (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && do_ins |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept && rsp_next.status == STATUS_FULL |-> is_full && !do_ins)
		else $error("full status without a full list");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != STATUS_OK |-> rsp_q.result_word == '0)
		else $error("error beat carries a word");

	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_ins && do_rem))
		else $error("insert and remove at once");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Indexed sequence store testbench
// Drives request beats into the sequence store and predicts every response
// with a local copy of the list: append, prepend, insert, remove and read,
// including the full and out-of-range cases. A directed pass and a fill under
// a long response hold-off come first, then random traffic with a drifting
// target length under three idling patterns. Each response is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import iss_pkg::*;

	localparam logic [2:0] MODE_TOP = 3'b111;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	word_t store_cells [CAPACITY];
	int store_count = 0;
	int target_len = 0;
	rsp_t pending_rsp [$];
	rsp_t oldest_rsp;
	int failures = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;

	indexed_sequence_store dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	task automatic predict_store(input req_t item, output rsp_t res);
		word_t stored_word;
		logic signed [63:0] wide;
		int slot;
		int i;
		res = '0;
		wide = item.data_word;
		stored_word = wide[WORD_BITS-1:0];
		case (item.mode)
			MODE_APPEND, MODE_PREPEND, MODE_INSERT: begin
				if (store_count >= CAPACITY) begin
					res.status = STATUS_FULL;
				end else begin
					if (item.mode == MODE_APPEND) begin
						slot = store_count;
					end else if (item.mode == MODE_PREPEND) begin
						slot = 0;
					end else begin
						slot = (item.position >= store_count) ? store_count : item.position;
					end
					for (i = store_count; i > slot; i--)
						store_cells[i] = store_cells[i-1];
					store_cells[slot] = stored_word;
					store_count++;
				end
			end
			MODE_REMOVE, MODE_READ: begin
				if (item.position >= store_count) begin
					res.status = STATUS_RANGE;
				end else begin
					wide = signed'(store_cells[item.position]);
					res.result_word = wide[31:0];
					if (item.mode == MODE_REMOVE) begin
						for (i = item.position; i + 1 < store_count; i++)
							store_cells[i] = store_cells[i+1];
						store_count--;
					end
				end
			end
			default: begin
			end
		endcase
		res.list_length = store_count[LEN_W-1:0];
	endtask

	function automatic req_t make_req(input logic [2:0] mode, input int position,
			input logic [31:0] data);
		req_t item;
		item.mode = mode;
		item.position = position[POS_W-1:0];
		item.data_word = data;
		return item;
	endfunction

	task automatic send_beat(input req_t item);
		rsp_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall !== 1'b0);
		predict_store(item, res);
		pending_rsp.push_back(res);
	endtask

	function automatic req_t next_random_request();
		req_t item;
		int pick;
		pick = $urandom_range(99);
		item.data_word = $urandom;
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: item.data_word = 32'h8000_0000;
				1: item.data_word = 32'h7FFF_FFFF;
				2: item.data_word = '0;
				default: item.data_word = '1;
			endcase
		end
		pick = $urandom_range(99);
		if (pick < 80) begin
			item.position = POS_W'($urandom_range(0, store_count));
		end else if (pick < 90) begin
			item.position = POS_W'(store_count + $urandom_range(0, 3));
		end else begin
			item.position = POS_W'($urandom);
		end
		if ($urandom_range(99) < 3)
			target_len = $urandom_range(0, CAPACITY);
		pick = $urandom_range(99);
		if (pick < 3) begin
			item.mode = 3'($urandom_range(MODE_READ + 1, MODE_TOP));
		end else if (pick < 25) begin
			item.mode = MODE_READ;
		end else if (store_count < target_len || (store_count == target_len && pick < 62)) begin
			case ($urandom_range(2))
				0: item.mode = MODE_APPEND;
				1: item.mode = MODE_PREPEND;
				default: item.mode = MODE_INSERT;
			endcase
		end else begin
			item.mode = MODE_REMOVE;
		end
		return item;
	endfunction

	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: response beat with nothing expected: %h", $time, rsp);
				failures++;
			end else begin
				oldest_rsp = pending_rsp.pop_front();
				if (rsp.status !== oldest_rsp.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						oldest_rsp.status, rsp.status);
					failures++;
				end
				if (rsp.result_word !== oldest_rsp.result_word) begin
					$display("%0t: result_word expected %h actual %h", $time,
						oldest_rsp.result_word, rsp.result_word);
					failures++;
				end
				if (rsp.list_length !== oldest_rsp.list_length) begin
					$display("%0t: list_length expected %0d actual %0d", $time,
						oldest_rsp.list_length, rsp.list_length);
					failures++;
				end
			end
		end
	end

	task automatic test_directed();
		logic [2:0] m;
		send_beat(make_req(MODE_READ, 0, 32'h0));
		send_beat(make_req(MODE_REMOVE, 0, 32'h0));
		send_beat(make_req(MODE_PREPEND, 0, 32'h7FFF_FFFF));
		send_beat(make_req(MODE_INSERT, 200, 32'h8000_0000));
		send_beat(make_req(MODE_INSERT, 0, 32'hFFFF_FFFF));
		send_beat(make_req(MODE_APPEND, 0, 32'h0));
		send_beat(make_req(MODE_INSERT, 2, 32'h5A5A_A5A5));
		send_beat(make_req(MODE_INSERT, store_count, 32'h0000_0001));
		send_beat(make_req(MODE_INSERT, 255, 32'hA5A5_5A5A));
		send_beat(make_req(MODE_READ, 0, 32'h0));
		send_beat(make_req(MODE_READ, store_count - 1, 32'h0));
		send_beat(make_req(MODE_READ, store_count, 32'h0));
		send_beat(make_req(MODE_READ, 255, 32'h0));
		send_beat(make_req(MODE_REMOVE, 255, 32'h0));
		send_beat(make_req(MODE_REMOVE, 0, 32'h0));
		send_beat(make_req(MODE_REMOVE, 2, 32'h0));
		send_beat(make_req(MODE_REMOVE, store_count - 1, 32'h0));
		for (m = MODE_READ + 3'd1; m != 3'b000; m++)
			send_beat(make_req(m, 255, 32'hFFFF_FFFF));
		send_beat(make_req(MODE_APPEND, 255, 32'hFFFF_FFFF));
	endtask

	// The response side is held off as the list starts to fill, so the block
	// backs up and stalls the request side; then every way of adding is tried
	// on the full list.
	task automatic test_fill_under_hold();
		hold_left = 64;
		while (store_count < CAPACITY)
			send_beat(make_req(MODE_APPEND, $urandom, $urandom));
		send_beat(make_req(MODE_APPEND, 0, $urandom));
		send_beat(make_req(MODE_PREPEND, 0, $urandom));
		send_beat(make_req(MODE_INSERT, $urandom_range(0, CAPACITY), $urandom));
		target_len = CAPACITY;
	endtask

	task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
			input int beats);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		repeat (beats) send_beat(next_random_request());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 23;
		recv_idle_pct = 80;
		test_directed();
		test_fill_under_hold();
		test_random_traffic(23, 80, 505);
		test_random_traffic(80, 23, 505);
		test_random_traffic(0, 0, 505);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (failures == 0) begin
			$display("indexed_sequence_store test passed");
		end else begin
			$display("indexed_sequence_store test failed");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("indexed_sequence_store test failed");
		$finish;
	end

endmodule
